FILE: rtl/itce_pkg.sv
// Shared constants, command codes and types of the ISO15693 tag command engine.
package itce_pkg;

   localparam int MEM_BYTES = 256;
   localparam int DEPTH     = MEM_BYTES / 4;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int SIZE_W    = 12;

   localparam logic [7:0] FLAG_INVENTORY = 8'h04;
   localparam logic [7:0] FLAG_SELECT    = 8'h10;
   localparam logic [7:0] FLAG_ADDRESS   = 8'h20;
   localparam logic [7:0] FLAG_OPTION    = 8'h40;

   localparam logic [7:0] OPC_INVENTORY   = 8'h01;
   localparam logic [7:0] OPC_STAY_QUIET  = 8'h02;
   localparam logic [7:0] OPC_READ_BLOCK  = 8'h20;
   localparam logic [7:0] OPC_WRITE_BLOCK = 8'h21;
   localparam logic [7:0] OPC_READ_MULTI  = 8'h23;
   localparam logic [7:0] OPC_SELECT      = 8'h25;
   localparam logic [7:0] OPC_RESET_READY = 8'h26;
   localparam logic [7:0] OPC_SYS_INFO    = 8'h2B;

   localparam logic [7:0] ERR_UNKNOWN_CMD = 8'h01;
   localparam logic [7:0] ERR_FORMAT      = 8'h02;
   localparam logic [7:0] ERR_RANGE       = 8'h10;
   localparam logic [7:0] ERR_LOCKED      = 8'h12;

   localparam logic [1:0] REG_TAG_UID   = 2'd0;
   localparam logic [1:0] REG_MEM_SIZE  = 2'd1;
   localparam logic [1:0] REG_READ_ONLY = 2'd2;

   localparam logic [63:0] UID_RESET   = 64'hE004_0205_0403_0201;
   localparam logic [8:0]  SIZE_RESET  = 9'd256;
   localparam logic [31:0] BLOCK1_INIT = 32'h00FE_0003;

   typedef struct packed {
      logic [119:0]      bytes;     // fixed leading bytes, first in low octet
      logic [3:0]        len;       // number of fixed bytes
      logic              rd;        // blocks follow the fixed bytes
      logic              opt;       // status byte before each block
      logic [ADDR_W-1:0] blk;
      logic [ADDR_W-1:0] nblk_m1;
      logic              wr;
      logic [31:0]       wdata;
      logic              changed;
      logic [31:0]       container;
   } job_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_HDR,
      B_FETCH,
      B_LOAD,
      B_BLOCK
   } back_state_type;

endpackage

FILE: rtl/itce_ram.sv
// Generic single-port-write, registered-read RAM.
module itce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/itce_front.sv
// Request decoder: checks flags, UID and lengths, keeps quiet/selected, builds jobs.
module itce_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             flags,
   input  logic [7:0]             command,
   input  logic [7:0]             frame_length,
   input  logic [63:0]            request_uid,
   input  logic [7:0]             first_block,
   input  logic [7:0]             block_count_minus_one,
   input  logic [31:0]            write_data,
   input  logic [10:0]            response_room,
   input  logic [63:0]            tag_uid,
   input  logic [8:0]             memory_size,
   input  logic                   read_only,
   output logic                   push,
   output itce_pkg::job_type      job
);
   import itce_pkg::*;

   logic quiet_ff, quiet_in, selected_ff, selected_in;
   logic [SIZE_W-1:0] size, room, len, idx, blk4, cnt, need;
   logic [7:0] units, blocks_m1;
   logic inv, addr, sel, opt;

   always_comb begin
      size = ({3'b0, memory_size} > SIZE_W'(MEM_BYTES)) ? SIZE_W'(MEM_BYTES)
                                                        : {3'b0, memory_size};
      units     = size[10:3];
      blocks_m1 = size[9:2] - 8'd1;
      room = {1'b0, response_room};
      len  = {4'b0, frame_length};
      inv  = (flags & FLAG_INVENTORY) != 8'd0;
      addr = (flags & FLAG_ADDRESS) != 8'd0;
      sel  = (flags & FLAG_SELECT) != 8'd0;
      opt  = (flags & FLAG_OPTION) != 8'd0;
      idx  = addr ? SIZE_W'(10) : SIZE_W'(2);
      blk4 = {2'b0, first_block, 2'b00};
      cnt  = {4'b0, block_count_minus_one} + SIZE_W'(1);
      need = SIZE_W'(1) + {cnt[9:0], 2'b00} + (opt ? cnt : SIZE_W'(0));
   end

   always_comb begin
      push        = 1'b0;
      job         = '0;
      quiet_in    = quiet_ff;
      selected_in = selected_ff;
      job.opt     = opt;
      job.blk     = first_block[ADDR_W-1:0];
      job.wdata   = write_data;
      job.container = {8'h01, units, (read_only ? 8'h4C : 8'h40), 8'hE1};
      if (req_valid && req_ready && len >= SIZE_W'(2)) begin
         if (inv) begin
            if (command == OPC_INVENTORY && !quiet_ff && room >= SIZE_W'(10)) begin
               push      = 1'b1;
               job.bytes = {40'b0, tag_uid, 16'h0000};
               job.len   = 4'd10;
            end
         end else if (addr && (len < SIZE_W'(10) || request_uid != tag_uid)) begin
            push = 1'b0;
         end else if (quiet_ff && !addr && !sel) begin
            push = 1'b0;
         end else if (sel && !selected_ff) begin
            push = 1'b0;
         end else begin
            // error reply by default; arms below override
            job.len   = 4'd2;
            job.bytes = {104'b0, ERR_FORMAT, 8'h01};
            unique case (command)
               OPC_STAY_QUIET: begin
                  if (addr) begin
                     quiet_in = 1'b1;
                  end
               end
               OPC_SELECT: begin
                  if (!addr) begin
                     push = room >= SIZE_W'(2);
                  end else if (room >= SIZE_W'(1)) begin
                     push        = 1'b1;
                     selected_in = 1'b1;
                     quiet_in    = 1'b0;
                     job.len     = 4'd1;
                     job.bytes   = '0;
                  end
               end
               OPC_RESET_READY: begin
                  if (room >= SIZE_W'(1)) begin
                     push        = 1'b1;
                     selected_in = 1'b0;
                     quiet_in    = 1'b0;
                     job.len     = 4'd1;
                     job.bytes   = '0;
                  end
               end
               OPC_READ_BLOCK: begin
                  if (len < idx + SIZE_W'(1)) begin
                     push = room >= SIZE_W'(2);
                  end else if (blk4 + SIZE_W'(4) > size) begin
                     push      = room >= SIZE_W'(2);
                     job.bytes = {104'b0, ERR_RANGE, 8'h01};
                  end else if ((opt ? SIZE_W'(6) : SIZE_W'(5)) <= room) begin
                     push      = 1'b1;
                     job.len   = 4'd1;
                     job.bytes = '0;
                     job.rd    = 1'b1;
                  end
               end
               OPC_READ_MULTI: begin
                  if (len < idx + SIZE_W'(2)) begin
                     push = room >= SIZE_W'(2);
                  end else if (blk4 + {cnt[9:0], 2'b00} > size) begin
                     push      = room >= SIZE_W'(2);
                     job.bytes = {104'b0, ERR_RANGE, 8'h01};
                  end else if (need <= room) begin
                     push        = 1'b1;
                     job.len     = 4'd1;
                     job.bytes   = '0;
                     job.rd      = 1'b1;
                     job.nblk_m1 = block_count_minus_one[ADDR_W-1:0];
                  end
               end
               OPC_WRITE_BLOCK: begin
                  if (len < idx + SIZE_W'(5)) begin
                     push = room >= SIZE_W'(2);
                  end else if (first_block == 8'd0 || read_only) begin
                     push      = room >= SIZE_W'(2);
                     job.bytes = {104'b0, ERR_LOCKED, 8'h01};
                  end else if (blk4 + SIZE_W'(4) > size) begin
                     push      = room >= SIZE_W'(2);
                     job.bytes = {104'b0, ERR_RANGE, 8'h01};
                  end else begin
                     // store even when the reply does not fit
                     push        = 1'b1;
                     job.wr      = 1'b1;
                     job.bytes   = '0;
                     job.len     = (room >= SIZE_W'(1)) ? 4'd1 : 4'd0;
                     job.changed = room >= SIZE_W'(1);
                  end
               end
               OPC_SYS_INFO: begin
                  if (room >= SIZE_W'(15)) begin
                     push      = 1'b1;
                     job.len   = 4'd15;
                     job.bytes = {8'h01, 8'h03, blocks_m1, 8'h00, 8'h00,
                                  tag_uid, 8'h0F, 8'h00};
                  end
               end
               default: begin
                  push      = room >= SIZE_W'(2);
                  job.bytes = {104'b0, ERR_UNKNOWN_CMD, 8'h01};
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_ff    <= 1'b0;
         selected_ff <= 1'b0;
      end else begin
         quiet_ff    <= quiet_in;
         selected_ff <= selected_in;
      end
   end
endmodule

FILE: rtl/itce_queue.sv
// Two-entry job queue between decoder and response builder.
module itce_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  itce_pkg::job_type push_job,
   output logic              push_ready,
   input  logic              pop,
   output logic              head_valid,
   output itce_pkg::job_type head_job
);
   import itce_pkg::*;

   job_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      push_ready = count_ff != 2'd2;
      head_valid = count_ff != 2'd0;
      head_job   = q_ff[rd_ptr_ff];
      do_push    = push && push_ready;
      do_pop     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff ^ do_push;
      rd_ptr_in  = rd_ptr_ff ^ do_pop;
      count_in   = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

FILE: rtl/itce_back.sv
// Response builder: runs jobs against tag memory; packs bytes into chunks of 1 to 8.
module itce_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  itce_pkg::job_type q_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [63:0]       rsp_bytes,
   output logic [3:0]        rsp_count,
   output logic              rsp_last,
   output logic              rsp_changed
);
   import itce_pkg::*;

   back_state_type    state_ff, state_in;
   job_type           job_ff;
   logic [3:0]        hidx_ff;
   logic [ADDR_W-1:0] cur_blk_ff, left_ff;
   logic [2:0]        bidx_ff;
   logic [31:0]       word_ff, word_in, rd_data;
   logic [DEPTH-1:0]  valid_ff;
   logic [63:0]       asm_data_ff, out_data_ff;
   logic [3:0]        asm_cnt_ff, out_cnt_ff;
   logic              asm_done_ff, asm_chg_ff;
   logic              out_valid_ff, out_last_ff, out_chg_ff;
   logic              can_app, app, app_final, xfer, ram_we, ram_re;
   logic [7:0]        app_byte;
   logic [1:0]        wsel;

   itce_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_job.blk),
      .wr_data (q_job.wdata),
      .rd_en   (ram_re),
      .rd_addr (cur_blk_ff),
      .rd_data (rd_data)
   );

   assign can_app = (asm_cnt_ff != 4'd8) && !asm_done_ff;
   assign xfer    = (asm_cnt_ff == 4'd8 || asm_done_ff) && (!out_valid_ff || rsp_ready);
   assign wsel    = bidx_ff[1:0] - 2'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid && q_job.len != 4'd0) begin
               state_in = B_HDR;
            end
         end
         B_HDR: begin
            if (can_app && hidx_ff == job_ff.len - 4'd1) begin
               state_in = job_ff.rd ? B_FETCH : B_IDLE;
            end
         end
         B_FETCH: state_in = B_LOAD;
         B_LOAD:  state_in = B_BLOCK;
         B_BLOCK: begin
            if (can_app && bidx_ff == 3'd4) begin
               state_in = (left_ff == '0) ? B_IDLE : B_FETCH;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      app       = 1'b0;
      app_final = 1'b0;
      app_byte  = 8'h00;
      unique case (state_ff)
         B_IDLE: begin
            pop    = q_valid;
            ram_we = q_valid && q_job.wr;
         end
         B_HDR: begin
            app       = can_app;
            app_byte  = job_ff.bytes[{hidx_ff, 3'b000} +: 8];
            app_final = can_app && hidx_ff == job_ff.len - 4'd1 && !job_ff.rd;
         end
         B_FETCH: ram_re = 1'b1;
         B_LOAD: begin
            app = 1'b0;
         end
         B_BLOCK: begin
            app       = can_app;
            app_byte  = (bidx_ff == 3'd0) ? 8'h00 : word_ff[{wsel, 3'b000} +: 8];
            app_final = can_app && bidx_ff == 3'd4 && left_ff == '0;
         end
         default: pop = 1'b0;
      endcase
   end

   always_comb begin
      if (cur_blk_ff == '0) begin
         word_in = job_ff.container;
      end else if (valid_ff[cur_blk_ff]) begin
         word_in = rd_data;
      end else if (cur_blk_ff == ADDR_W'(1)) begin
         word_in = BLOCK1_INIT;
      end else begin
         word_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff     <= q_job;
         hidx_ff    <= 4'd0;
         cur_blk_ff <= q_job.blk;
         left_ff    <= q_job.nblk_m1;
      end
      if (state_ff == B_HDR && can_app) begin
         hidx_ff <= hidx_ff + 4'd1;
      end
      if (state_ff == B_LOAD) begin
         word_ff <= word_in;
         bidx_ff <= job_ff.opt ? 3'd0 : 3'd1;
      end
      if (state_ff == B_BLOCK && can_app) begin
         bidx_ff <= bidx_ff + 3'd1;
         if (bidx_ff == 3'd4) begin
            cur_blk_ff <= cur_blk_ff + ADDR_W'(1);
            left_ff    <= left_ff - ADDR_W'(1);
         end
      end
      if (app) begin
         if (asm_cnt_ff == 4'd0) begin
            asm_data_ff <= {56'b0, app_byte};
         end else begin
            asm_data_ff[{asm_cnt_ff[2:0], 3'b000} +: 8] <= app_byte;
         end
         asm_chg_ff <= job_ff.changed;
      end
      if (xfer) begin
         out_data_ff <= asm_data_ff;
         out_cnt_ff  <= asm_cnt_ff;
         out_last_ff <= asm_done_ff;
         out_chg_ff  <= asm_chg_ff;
      end
      if (reset) begin
         state_ff     <= B_IDLE;
         valid_ff     <= '0;
         asm_cnt_ff   <= 4'd0;
         asm_done_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ram_we) begin
            valid_ff[q_job.blk] <= 1'b1;
         end
         if (xfer) begin
            asm_cnt_ff  <= 4'd0;
            asm_done_ff <= 1'b0;
         end else if (app) begin
            asm_cnt_ff  <= asm_cnt_ff + 4'd1;
            asm_done_ff <= app_final;
         end
         if (xfer) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_bytes   = out_data_ff;
   assign rsp_count   = out_cnt_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_changed = out_chg_ff;

   a_asm_bound: assert property (@(posedge clock) disable iff (reset)
      asm_cnt_ff <= 4'd8) else $error("chunk assembly overflow");
   a_out_nonempty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_cnt_ff != 4'd0)) else $error("empty chunk offered");
   a_no_append_full: assert property (@(posedge clock) disable iff (reset)
      app |-> !xfer) else $error("append and transfer collide");
   a_fetch_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FETCH) |=> (state_ff == B_LOAD)) else $error("memory read lost");
endmodule

FILE: rtl/iso15693_tag_command_engine_unit.sv
// Top level of the ISO15693 tag command engine.
// Usage:
//   req_* carries one decoded request per transfer (flags, command, frame length,
//   UID, block number, block count, write data, response room). rsp_* returns the
//   response as chunks of up to 8 bytes, first byte in the low octet, with
//   rsp_tlast on the final chunk and rsp_tuser set on the reply of a stored
//   write. csr_* writes tag_uid (0), memory_size (1) and read_only (2); the
//   user writes them only while idle, which the block does not enforce.
// Timing:
//   The decoder takes a request every cycle while its two-entry job queue has
//   room; silent requests leave nothing behind. The builder appends one byte per
//   cycle while its output is not stalled, pausing for each job, for the memory
//   read of each block (B_FETCH, B_LOAD) and for each full chunk handed on. A
//   reply of up to 8 bytes without blocks is offered after passing the queue,
//   the builder's job register, the assembly register and the output register.
// Reset clears quiet, selected and the written marks of the tag memory, which
//   then reads as zeros except block 0 (container) and block 1 (empty NDEF TLV).
// When rsp_tready is low the builder holds its finished chunk and one more in
//   assembly, then stalls; the queue fills and req_tready drops.
module iso15693_tag_command_engine_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // flags, command, frame_length, request_uid, first_block,
   // block_count_minus_one, write_data, response_room, zero pad
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // response_bytes, byte_count, zero pad
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tlast,
   // memory_changed
   output logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   import itce_pkg::*;

   logic [63:0] uid_ff;
   logic [8:0]  msize_ff;
   logic        ro_ff;
   logic        push, push_ready, q_valid, pop;
   job_type     push_job, q_job;
   logic [63:0] rsp_bytes;
   logic [3:0]  rsp_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         uid_ff   <= UID_RESET;
         msize_ff <= SIZE_RESET;
         ro_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TAG_UID:   uid_ff   <= csr_wdata;
            REG_MEM_SIZE:  msize_ff <= csr_wdata[8:0];
            REG_READ_ONLY: ro_ff    <= csr_wdata[0];
            default:       ro_ff    <= ro_ff;
         endcase
      end
   end

   assign req_tready = push_ready;

   itce_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_tvalid),
      .req_ready             (push_ready),
      .flags                 (req_tdata[7:0]),
      .command               (req_tdata[15:8]),
      .frame_length          (req_tdata[23:16]),
      .request_uid           (req_tdata[87:24]),
      .first_block           (req_tdata[95:88]),
      .block_count_minus_one (req_tdata[103:96]),
      .write_data            (req_tdata[135:104]),
      .response_room         (req_tdata[146:136]),
      .tag_uid               (uid_ff),
      .memory_size           (msize_ff),
      .read_only             (ro_ff),
      .push                  (push),
      .job                   (push_job)
   );

   itce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (q_valid),
      .head_job   (q_job)
   );

   itce_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_job       (q_job),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_bytes   (rsp_bytes),
      .rsp_count   (rsp_count),
      .rsp_last    (rsp_tlast),
      .rsp_changed (rsp_tuser)
   );

   assign rsp_tdata = {4'b0, rsp_count, rsp_bytes};
endmodule
